// ===== design/streaming_top_k_by_score_unit_macros.svh =====
// Assertion macros shared by the streaming top-K ranker.
// Depends on nothing; files that assert include it and provide clk and arst_n.
`ifndef STREAMING_TOP_K_BY_SCORE_UNIT_MACROS_SVH
`define STREAMING_TOP_K_BY_SCORE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define STK_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define STK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/stk_pkg.sv =====
// Package for the streaming top-K ranker: field widths, item codes, entry and cell types.
// Depends on nothing.
package stk_pkg;

	localparam int ID_W    = 16;
	localparam int SCORE_W = 10;
	localparam int TOTAL_W = 11;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef struct packed {
		logic               used;
		logic [ID_W-1:0]    id;
		logic [TOTAL_W-1:0] total;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic clr;
	} cell_ctrl_t;

endpackage

// ===== design/stk_cell.sv =====
// One ranking cell: holds a single entry, compares it with the incoming record
// and either keeps it, takes the record, or takes its neighbour's entry. Uses stk_pkg.
module stk_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  stk_pkg::cell_ctrl_t ctrl,
	input  stk_pkg::entry_t     new_entry,
	input  logic                prev_take,
	input  stk_pkg::entry_t     prev_entry,
	output logic                take,
	output stk_pkg::entry_t     entry
);

	stk_pkg::entry_t entry_q;

	// strictly smaller total loses its place; ties keep the older record ahead
	assign take  = ctrl.ins && (!entry_q.used || (entry_q.total < new_entry.total));
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.clr) begin
			entry_q <= '0;
		end else if (take) begin
			entry_q <= prev_take ? prev_entry : new_entry;
		end
	end

endmodule

// ===== design/stk_drain.sv =====
// Report drain: a snapshot shift line that hands ranked entries to the output one per
// transaction, head first. Uses stk_pkg and the assertion macros header.
`include "streaming_top_k_by_score_unit_macros.svh"

module stk_drain #(
	parameter int TOP_K = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  stk_pkg::entry_t             snap [TOP_K],
	output logic                        busy,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        entry_valid,
	output logic [stk_pkg::ID_W-1:0]    entry_id,
	output logic [stk_pkg::TOTAL_W-1:0] entry_total,
	output logic                        is_last
);

	stk_pkg::entry_t line_q [TOP_K];
	logic            empty_q;
	logic            next_used;
	logic            out_acc;

	generate
		if (TOP_K > 1) begin : g_next
			assign next_used = line_q[1].used;
		end else begin : g_single
			assign next_used = 1'b0;
		end
	endgenerate

	assign out_valid   = line_q[0].used || empty_q;
	assign busy        = out_valid;
	assign out_acc     = out_valid && !out_stall;
	assign entry_valid = line_q[0].used;
	assign entry_id    = line_q[0].id;
	assign entry_total = line_q[0].total;
	assign is_last     = empty_q || !next_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOP_K; i++) begin
				line_q[i] <= '0;
			end
			empty_q <= 1'b0;
		end else if (load) begin
			for (int i = 0; i < TOP_K; i++) begin
				line_q[i] <= snap[i];
			end
			empty_q <= !snap[0].used;
		end else if (out_acc) begin
			for (int i = 0; i < TOP_K - 1; i++) begin
				line_q[i] <= line_q[i+1];
			end
			line_q[TOP_K-1] <= '0;
			empty_q         <= 1'b0;
		end
	end

	`STK_ASSERT_SAME(a_load_idle, load, !busy, "report loaded while drain still busy")
	`STK_ASSERT_SAME(a_empty_clean, empty_q, !line_q[0].used, "empty report with stored entry")
	`STK_ASSERT_NEXT(a_last_ends, out_acc && is_last, !out_valid, "result after last of report")

	generate
		for (genvar g = 0; g + 1 < TOP_K; g++) begin : g_chk
			`STK_ASSERT_SAME(a_prefix, line_q[g+1].used, line_q[g].used, "drain holes in line")
		end
	endgenerate

endmodule

// ===== design/streaming_top_k_by_score_unit.sv =====
// Streaming top-K ranker: keeps the TOP_K records with the highest total of two
// scores in a descending chain of cells, and reports then clears them on request.
// Depends on stk_pkg, stk_cell, stk_drain and the assertion macros header.
//
// An insert transaction is taken every cycle: each record is compared against all
// TOP_K cells at once and the chain shifts by one in that same cycle. A report, when
// taken, copies the chain into the drain line and clears the chain, so inserts
// continue at once. Its results then leave one per cycle while out_stall is low
// (one to TOP_K results). A further report is held off by in_stall until every
// result of the previous report has been taken.
// No result is produced for an insert. Reset needs no clearing pass.
`include "streaming_top_k_by_score_unit_macros.svh"

module streaming_top_k_by_score_unit #(
	parameter int TOP_K = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [stk_pkg::ID_W-1:0]    record_id,
	input  logic [stk_pkg::SCORE_W-1:0] first_score,
	input  logic [stk_pkg::SCORE_W-1:0] second_score,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        entry_valid,
	output logic [stk_pkg::ID_W-1:0]    entry_id,
	output logic [stk_pkg::TOTAL_W-1:0] entry_total,
	output logic                        is_last
);

	logic                busy;
	logic                in_acc;
	logic                report;
	stk_pkg::cell_ctrl_t ctrl;
	stk_pkg::entry_t     new_entry;
	logic                take [TOP_K];
	stk_pkg::entry_t     cell_entry [TOP_K];

	assign in_stall  = (kind == stk_pkg::KIND_REPORT) && busy;
	assign in_acc    = in_valid && !in_stall;
	assign report    = in_acc && (kind == stk_pkg::KIND_REPORT);
	assign ctrl.ins  = in_acc && (kind == stk_pkg::KIND_INSERT);
	assign ctrl.clr  = report;

	assign new_entry.used  = 1'b1;
	assign new_entry.id    = record_id;
	assign new_entry.total = {1'b0, first_score} + {1'b0, second_score};

	generate
		for (genvar g = 0; g < TOP_K; g++) begin : g_cell
			if (g == 0) begin : g_head
				stk_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.new_entry  (new_entry),
					.prev_take  (1'b0),
					.prev_entry ('0),
					.take       (take[g]),
					.entry      (cell_entry[g])
				);
			end else begin : g_body
				stk_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.new_entry  (new_entry),
					.prev_take  (take[g-1]),
					.prev_entry (cell_entry[g-1]),
					.take       (take[g]),
					.entry      (cell_entry[g])
				);
			end
		end
	endgenerate

	stk_drain #(
		.TOP_K (TOP_K)
	) u_drain (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (report),
		.snap        (cell_entry),
		.busy        (busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.entry_valid (entry_valid),
		.entry_id    (entry_id),
		.entry_total (entry_total),
		.is_last     (is_last)
	);

	`STK_ASSERT_NEXT(a_report_clears, report, !cell_entry[0].used, "chain not cleared by report")
	`STK_ASSERT_NEXT(a_report_drains, report, out_valid, "report gave no result")

	generate
		for (genvar g = 0; g + 1 < TOP_K; g++) begin : g_chk
			`STK_ASSERT_SAME(a_order, cell_entry[g+1].used, cell_entry[g].used && (cell_entry[g].total >= cell_entry[g+1].total), "chain out of order")
		end
	endgenerate

endmodule

// ===== tb/streaming_top_k_by_score_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for streaming_top_k_by_score_unit: directed and random record and report traffic,
// checked against an in-bench ranking of the top three totals. Depends on stk_pkg and the unit.
module streaming_top_k_by_score_unit_tb;

	localparam int TOP_K          = 3;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic                        valid;
		logic [stk_pkg::ID_W-1:0]    id;
		logic [stk_pkg::TOTAL_W-1:0] total;
		logic                        last;
	} ranked_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic                        kind;
	logic [stk_pkg::ID_W-1:0]    record_id;
	logic [stk_pkg::SCORE_W-1:0] first_score;
	logic [stk_pkg::SCORE_W-1:0] second_score;
	logic                        out_valid;
	logic                        out_stall;
	logic                        entry_valid;
	logic [stk_pkg::ID_W-1:0]    entry_id;
	logic [stk_pkg::TOTAL_W-1:0] entry_total;
	logic                        is_last;

	stk_pkg::entry_t ranked_store [TOP_K];
	ranked_result_t  pending_results [$];

	int tx_gap_pct;
	int rx_stall_pct;
	int hold_len;
	int stuck_cycles;
	int n_errors;
	int n_sent;
	int n_reports;
	int n_dropped;
	int n_results;

	streaming_top_k_by_score_unit #(
		.TOP_K(TOP_K)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.record_id   (record_id),
		.first_score (first_score),
		.second_score(second_score),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.entry_valid (entry_valid),
		.entry_id    (entry_id),
		.entry_total (entry_total),
		.is_last     (is_last)
	);

	always #6 clk = ~clk;

	function automatic void rank_insert(logic [stk_pkg::ID_W-1:0] id,
			logic [stk_pkg::TOTAL_W-1:0] total);
		int pos;
		pos = 0;
		while (pos < TOP_K && ranked_store[pos].used && ranked_store[pos].total >= total)
			pos++;
		if (pos >= TOP_K) begin
			n_dropped++;
			return;
		end
		for (int j = TOP_K - 1; j > pos; j--)
			ranked_store[j] = ranked_store[j - 1];
		ranked_store[pos].used  = 1'b1;
		ranked_store[pos].id    = id;
		ranked_store[pos].total = total;
	endfunction

	function automatic void rank_report();
		ranked_result_t r;
		int n;
		n = 0;
		for (int i = 0; i < TOP_K; i++) begin
			if (!ranked_store[i].used)
				break;
			r.valid = 1'b1;
			r.id    = ranked_store[i].id;
			r.total = ranked_store[i].total;
			r.last  = 1'b0;
			pending_results.push_back(r);
			n++;
		end
		if (n == 0) begin
			r = '0;
			r.last = 1'b1;
			pending_results.push_back(r);
		end else begin
			pending_results[pending_results.size() - 1].last = 1'b1;
		end
		for (int i = 0; i < TOP_K; i++)
			ranked_store[i] = '0;
		n_reports++;
	endfunction

	task automatic flag_error(input string what);
		n_errors++;
		$display("ERROR at %0t: %s", $time, what);
	endtask

	task automatic send_item(input logic k, input logic [stk_pkg::ID_W-1:0] id,
			input logic [stk_pkg::SCORE_W-1:0] a, input logic [stk_pkg::SCORE_W-1:0] b);
		int gap;
		logic [stk_pkg::TOTAL_W-1:0] total;
		gap = 0;
		while ($urandom_range(0, 99) < tx_gap_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		record_id    <= id;
		first_score  <= a;
		second_score <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		total = a;
		total = total + b;
		if (k == stk_pkg::KIND_INSERT)
			rank_insert(id, total);
		else
			rank_report();
		n_sent++;
	endtask

	task automatic insert_record(input logic [stk_pkg::ID_W-1:0] id,
			input logic [stk_pkg::SCORE_W-1:0] a, input logic [stk_pkg::SCORE_W-1:0] b);
		send_item(stk_pkg::KIND_INSERT, id, a, b);
	endtask

	// score and id fields of a report are don't-care, so fill them with noise
	task automatic request_report();
		send_item(stk_pkg::KIND_REPORT, stk_pkg::ID_W'($urandom_range(0, 65535)),
			stk_pkg::SCORE_W'($urandom_range(0, 1023)),
			stk_pkg::SCORE_W'($urandom_range(0, 1023)));
	endtask

	// receiver: random stall, or a long hold-off while hold_len runs down
	always @(posedge clk) begin
		if (hold_len > 0) begin
			out_stall <= 1'b1;
			hold_len--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		ranked_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			n_results++;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected result id %h total %0d", entry_id, entry_total));
			end else begin
				want = pending_results.pop_front();
				if (entry_valid !== want.valid)
					flag_error($sformatf("entry_valid %b, expected %b", entry_valid, want.valid));
				if (entry_id !== want.id)
					flag_error($sformatf("entry_id %h, expected %h", entry_id, want.id));
				if (entry_total !== want.total)
					flag_error($sformatf("entry_total %0d, expected %0d",
						entry_total, want.total));
				if (is_last !== want.last)
					flag_error($sformatf("is_last %b, expected %b", is_last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", stuck_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic test_empty_report();
		request_report();
		request_report();
	endtask

	task automatic test_single_entry();
		insert_record(16'h1234, 10'd7, 10'd9);
		request_report();
	endtask

	// equal totals keep arrival order; an equal total on a full list is dropped
	task automatic test_tie_order();
		insert_record(16'h0001, 10'd100, 10'd0);
		insert_record(16'h0002, 10'd0, 10'd100);
		insert_record(16'h0003, 10'd50, 10'd50);
		insert_record(16'h0004, 10'd99, 10'd1);
		request_report();
	endtask

	task automatic test_score_extremes();
		insert_record(16'h0000, 10'd0, 10'd0);
		insert_record(16'hFFFF, 10'd1023, 10'd1023);
		insert_record(16'h5555, 10'd1023, 10'd0);
		insert_record(16'hAAAA, 10'd0, 10'd1023);
		request_report();
	endtask

	task automatic test_full_list();
		insert_record(16'h0010, 10'd300, 10'd0);
		insert_record(16'h0011, 10'd200, 10'd0);
		insert_record(16'h0012, 10'd100, 10'd0);
		insert_record(16'h0013, 10'd50, 10'd0);
		insert_record(16'h0014, 10'd250, 10'd0);
		insert_record(16'h0015, 10'd1000, 10'd0);
		request_report();
	endtask

	// hold the output off so the drain line backs up and the input stalls
	task automatic test_output_backpressure();
		hold_len = 150;
		for (int r = 0; r < 4; r++) begin
			repeat (r + 1)
				insert_record(stk_pkg::ID_W'($urandom_range(0, 65535)),
					stk_pkg::SCORE_W'($urandom_range(0, 1023)),
					stk_pkg::SCORE_W'($urandom_range(0, 1023)));
			request_report();
		end
	endtask

	task automatic test_random_traffic(input int n_items);
		int sent;
		int burst;
		int mode;
		logic [stk_pkg::SCORE_W-1:0] a;
		logic [stk_pkg::SCORE_W-1:0] b;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(0, 6);
			mode  = $urandom_range(0, 2);
			repeat (burst) begin
				case (mode)
					0: begin
						a = stk_pkg::SCORE_W'($urandom_range(0, 1023));
						b = stk_pkg::SCORE_W'($urandom_range(0, 1023));
					end
					1: begin
						a = stk_pkg::SCORE_W'($urandom_range(500, 503));
						b = stk_pkg::SCORE_W'($urandom_range(0, 3));
					end
					default: begin
						a = $urandom_range(0, 1) ? '1 : '0;
						b = $urandom_range(0, 1) ? '1 : '0;
					end
				endcase
				insert_record(stk_pkg::ID_W'($urandom_range(0, 65535)), a, b);
				sent++;
			end
			if ($urandom_range(0, 9) != 0) begin
				request_report();
				sent++;
			end
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		kind         <= stk_pkg::KIND_INSERT;
		record_id    <= '0;
		first_score  <= '0;
		second_score <= '0;
		out_stall    <= 1'b0;
		hold_len     = 0;
		stuck_cycles = 0;
		n_errors     = 0;
		n_sent       = 0;
		n_reports    = 0;
		n_dropped    = 0;
		n_results    = 0;
		for (int i = 0; i < TOP_K; i++)
			ranked_store[i] = '0;
		tx_gap_pct   = 6;
		rx_stall_pct = 51;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_report();
		test_single_entry();
		test_tie_order();
		test_score_extremes();
		test_full_list();
		test_random_traffic(115);

		tx_gap_pct   = 51;
		rx_stall_pct = 6;
		test_random_traffic(115);

		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		test_output_backpressure();
		test_random_traffic(115);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * TOP_K + 4) @(posedge clk);

		$display("Covered %0d transactions (%0d reports, %0d records dropped), %0d results out",
			n_sent, n_reports, n_dropped, n_results);
		$display("Ties, full lists, empty reports, score extremes and long output hold-off run");
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/stk_pkg.sv
design/stk_cell.sv
design/stk_drain.sv
design/streaming_top_k_by_score_unit.sv
tb/streaming_top_k_by_score_unit_tb.sv
